FILE: sv/pra_pkg.sv
// Shared types, constants and helpers for the prefetch request arbiter.
`timescale 1ns / 1ps

package pra_pkg;

    // Storage sizes of the pending queue and the recent filter.
    localparam int PEND_DEPTH = 18;
    localparam int PEND_IDX_W = $clog2(PEND_DEPTH);
    localparam int CNT_W      = $clog2(PEND_DEPTH + 1);
    localparam int FILT_DEPTH = 64;
    localparam int FILT_IDX_W = $clog2(FILT_DEPTH);
    localparam int FILT_CNT_W = $clog2(FILT_DEPTH + 1);
    localparam int TIME_W     = 32;
    localparam int IN_SOURCES = 2;

    typedef logic [TIME_W-1:0] t_time;

    // Main sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CANCEL,
        S_REQ,
        S_SCAN,
        S_INSERT,
        S_DRAIN,
        S_DONE
    } t_state;

    // Commands to the filter unit.
    typedef struct packed {
        logic start;
        logic insert;
    } t_flt_ctl;

    // Status from the filter unit.
    typedef struct packed {
        logic done;
        logic hit;
    } t_flt_sts;

    // A time stamp has come when it lies less than half the range behind now.
    function automatic logic has_come(input t_time now_t, input t_time stamp);
        t_time diff;
        diff = now_t - stamp;
        return ~diff[TIME_W-1];
    endfunction

endpackage

FILE: sv/pra_in_if.sv
// Input channel interface: one demand access with two prefetch candidates.
`timescale 1ns / 1ps

interface pra_in_if #(parameter int ADDR_W = 48) ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] demand_addr;
    logic              req0_valid;
    logic [ADDR_W-1:0] req0_addr;
    logic              req1_valid;
    logic [ADDR_W-1:0] req1_addr;

    modport source (output valid, demand_addr, req0_valid, req0_addr, req1_valid, req1_addr,
                    input ready);
    modport sink (input valid, demand_addr, req0_valid, req0_addr, req1_valid, req1_addr,
                  output ready);
endinterface

FILE: sv/pra_out_if.sv
// Output channel interface: the per-access issue result.
`timescale 1ns / 1ps

interface pra_out_if #(parameter int ADDR_W = 48) ();
    logic              valid;
    logic              ready;
    logic              issue_valid;
    logic [ADDR_W-1:0] issue_addr;
    logic              issue_source;
    logic [1:0]        dropped_mask;
    logic [4:0]        cancel_count;

    modport source (output valid, issue_valid, issue_addr, issue_source, dropped_mask,
                    cancel_count, input ready);
    modport sink (input valid, issue_valid, issue_addr, issue_source, dropped_mask,
                  cancel_count, output ready);
endinterface

FILE: sv/pra_filter.sv
// Recent-request filter: a ring memory scanned one entry per cycle.
`timescale 1ns / 1ps

module pra_filter
    import pra_pkg::*;
#(
    parameter int ADDR_W = 48,
    parameter int REPEAT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_flt_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_key,
    input  t_time             i_now,
    output t_flt_sts          o_sts
);

    logic [ADDR_W-1:0]     mem_addr [FILT_DEPTH];
    t_time                 mem_exp  [FILT_DEPTH];
    logic [FILT_DEPTH-1:0] r_val;
    logic [FILT_IDX_W-1:0] r_wp;
    logic [FILT_CNT_W-1:0] r_k;
    logic                  r_run;
    logic                  r_rd_vld;
    logic [FILT_IDX_W-1:0] r_rd_idx;
    logic [ADDR_W-1:0]     r_rd_addr;
    t_time                 r_rd_exp;
    logic                  r_hit;
    logic                  r_done;
    logic                  rd_issue;

    assign rd_issue = r_run && (r_k < FILT_CNT_W'(FILT_DEPTH));

    // Memory write on insert and registered read during the scan.
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            mem_addr[r_wp] <= i_key;
            mem_exp[r_wp]  <= i_now + TIME_W'(REPEAT);
        end
        if (rd_issue) begin
            r_rd_addr <= mem_addr[r_k[FILT_IDX_W-1:0]];
            r_rd_exp  <= mem_exp[r_k[FILT_IDX_W-1:0]];
        end
        r_rd_idx <= r_k[FILT_IDX_W-1:0];
    end

    // Scan control: expire stale entries and look for the key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val    <= '0;
            r_wp     <= '0;
            r_k      <= '0;
            r_run    <= 1'b0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_rd_vld <= rd_issue;
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_k   <= '0;
                r_hit <= 1'b0;
            end else if (rd_issue) begin
                r_k <= r_k + 1'b1;
            end else if (r_run && !r_rd_vld) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
            if (r_rd_vld && r_val[r_rd_idx]) begin
                if (has_come(i_now, r_rd_exp)) begin
                    r_val[r_rd_idx] <= 1'b0;
                end else if (r_rd_addr == i_key) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_ctl.insert) begin
                r_val[r_wp] <= 1'b1;
                r_wp        <= r_wp + 1'b1;
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.hit  = r_hit;

endmodule

FILE: sv/prefetch_request_arbiter_core.sv
// Top level of the prefetch request arbiter with duplicate filter.
// Usage: i_in carries one demand access per transaction, with up to two
// prefetch candidates. o_out returns exactly one result transaction per
// input transaction, in order.
// Sequence: accept the transaction, walk the queue and cancel the entries
// that match the demand address, then for each source skip it or, for a
// valid request, scan the filter memory one entry per cycle and queue the
// request if the filter misses and the queue has room, then issue the
// first due entry, drop the later due ones, and present the result.
// Throughput: one transaction at a time; i_in.ready is high only when the
// sequencer is idle.
// Reset: time, the queue and the filter are emptied at once; no clearing
// pass is needed.
// Stall: the result waits in an output register while o_out.ready is low;
// a new transaction can be taken meanwhile, but its result is held back
// until the earlier one has been taken.
`timescale 1ns / 1ps

module prefetch_request_arbiter_core
    import pra_pkg::*;
#(
    parameter int DELAY       = 8,
    parameter int REPEAT      = 32,
    parameter int NUM_SOURCES = 2,
    parameter int ADDR_W      = 48
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pra_in_if.sink   i_in,
    pra_out_if.source o_out
);

    t_state                r_state, n_state;
    t_time                 r_now;
    logic [ADDR_W-1:0]     r_demand;
    logic [ADDR_W-1:0]     r_req_addr [IN_SOURCES];
    logic [IN_SOURCES-1:0] r_req_vld;
    logic                  r_src;
    logic                  r_src_end;
    logic [CNT_W-1:0]      r_i;
    logic [CNT_W-1:0]      r_count;
    logic [4:0]            r_cancel;
    logic                  r_iv;
    logic [ADDR_W-1:0]     r_ia;
    logic                  r_is;
    logic [1:0]            r_dm;
    logic [ADDR_W-1:0]     r_pa [PEND_DEPTH];
    t_time                 r_pr [PEND_DEPTH];
    logic                  r_ps [PEND_DEPTH];
    logic                  r_ov;
    logic                  r_o_iv;
    logic [ADDR_W-1:0]     r_o_ia;
    logic                  r_o_is;
    logic [1:0]            r_o_dm;
    logic [4:0]            r_o_cc;

    t_flt_ctl              flt_ctl;
    t_flt_sts              flt_sts;
    logic                  accept;
    logic                  walk_match;
    logic                  head_due;
    logic                  src_last;
    logic                  shift_en;
    logic [CNT_W-1:0]      shift_base;
    logic                  load_out;

    assign accept     = i_in.valid && i_in.ready;
    assign walk_match = (r_i < r_count) && (r_pa[r_i[PEND_IDX_W-1:0]] == r_demand);
    assign head_due   = (r_count != '0) && has_come(r_now, r_pr[0]);
    assign src_last   = (NUM_SOURCES < 2) || r_src;
    assign load_out   = (r_state == S_DONE) && (!r_ov || o_out.ready);

    // Filter unit with its ring memory.
    pra_filter #(
        .ADDR_W (ADDR_W),
        .REPEAT (REPEAT)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (flt_ctl),
        .i_key   (r_req_addr[r_src]),
        .i_now   (r_now),
        .o_sts   (flt_sts)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer controls.
    always_comb begin
        n_state        = r_state;
        flt_ctl        = '0;
        shift_en       = 1'b0;
        shift_base     = '0;
        i_in.ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (accept) begin
                    n_state = S_CANCEL;
                end
            end
            S_CANCEL: begin
                if (r_i >= r_count) begin
                    n_state = S_REQ;
                end else if (walk_match) begin
                    shift_en   = 1'b1;
                    shift_base = r_i;
                end
            end
            S_REQ: begin
                if (r_src_end) begin
                    n_state = S_DRAIN;
                end else if (r_req_vld[r_src]) begin
                    flt_ctl.start = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (flt_sts.done) begin
                    n_state = flt_sts.hit ? S_REQ : S_INSERT;
                end
            end
            S_INSERT: begin
                flt_ctl.insert = (r_count < CNT_W'(PEND_DEPTH));
                n_state        = S_REQ;
            end
            S_DRAIN: begin
                if (head_due) begin
                    shift_en = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control counters and per-access result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_count   <= '0;
            r_i       <= '0;
            r_src     <= 1'b0;
            r_src_end <= 1'b0;
            r_cancel  <= '0;
            r_iv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (accept) begin
                r_now     <= r_now + 1'b1;
                r_i       <= '0;
                r_src     <= 1'b0;
                r_src_end <= 1'b0;
                r_cancel  <= '0;
                r_iv      <= 1'b0;
            end
            if (r_state == S_CANCEL && r_i < r_count) begin
                if (walk_match) begin
                    r_cancel <= r_cancel + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            // Advance the source after a skip, a filter hit or an insert.
            if ((r_state == S_REQ && !r_src_end && !r_req_vld[r_src]) ||
                (r_state == S_SCAN && flt_sts.done && flt_sts.hit) ||
                (r_state == S_INSERT)) begin
                if (src_last) begin
                    r_src_end <= 1'b1;
                end else begin
                    r_src <= 1'b1;
                end
            end
            if (r_state == S_DRAIN && head_due) begin
                r_iv <= 1'b1;
            end
            if (shift_en) begin
                r_count <= r_count - 1'b1;
            end else if (flt_ctl.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers: the accepted transaction, queue contents and result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_demand      <= i_in.demand_addr;
            r_req_addr[0] <= i_in.req0_addr;
            r_req_addr[1] <= i_in.req1_addr;
            r_req_vld     <= {i_in.req1_valid, i_in.req0_valid};
            r_ia          <= '0;
            r_is          <= 1'b0;
            r_dm          <= '0;
        end
        if (r_state == S_DRAIN && head_due) begin
            if (!r_iv) begin
                r_ia <= r_pa[0];
                r_is <= r_ps[0];
            end else begin
                r_dm[r_ps[0]] <= 1'b1;
            end
        end
        for (int j = 0; j < PEND_DEPTH; j++) begin
            if (shift_en && j < PEND_DEPTH - 1 && CNT_W'(j) >= shift_base) begin
                r_pa[j] <= r_pa[(j + 1) % PEND_DEPTH];
                r_pr[j] <= r_pr[(j + 1) % PEND_DEPTH];
                r_ps[j] <= r_ps[(j + 1) % PEND_DEPTH];
            end else if (flt_ctl.insert && CNT_W'(j) == r_count) begin
                r_pa[j] <= r_req_addr[r_src];
                r_pr[j] <= r_now + TIME_W'(DELAY);
                r_ps[j] <= r_src;
            end
        end
        if (load_out) begin
            r_o_iv <= r_iv;
            r_o_ia <= r_ia;
            r_o_is <= r_is;
            r_o_dm <= r_dm;
            r_o_cc <= r_cancel;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.issue_valid  = r_o_iv;
    assign o_out.issue_addr   = r_o_ia;
    assign o_out.issue_source = r_o_is;
    assign o_out.dropped_mask = r_o_dm;
    assign o_out.cancel_count = r_o_cc;

`ifndef SYNTHESIS
    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PEND_DEPTH))
        else $error("pending queue count exceeds depth");

    // An accepted transaction always starts with the cancel walk.
    a_start_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_CANCEL)
        else $error("accepted transaction did not enter cancel walk");

    // Draining an empty queue ends the transaction.
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && r_count == '0) |=> r_state == S_DONE)
        else $error("drain did not finish on empty queue");
`endif

endmodule
